// ===== rtl/ebau_pkg.sv =====
// ----------------------------------------------------------------------------
// ebau_pkg
// Shared types and constants of the epsilon-box archive update block.
// ----------------------------------------------------------------------------
package ebau_pkg;

	localparam int OBJ_PORT_W = 32;
	localparam int EPS_W      = 32;
	localparam int SQ_W       = 66;
	localparam int CNT_OUT_W  = 9;

	localparam logic REG_EPSILON   = 1'b0;
	localparam logic [31:0] EPS_RESET = 32'd655;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_DRAIN_C,
		ST_READ,
		ST_CMP,
		ST_DIST,
		ST_DRAIN_E,
		ST_DECIDE,
		ST_CP_RD,
		ST_CP_WR,
		ST_DONE
	} ebau_state_t;

	typedef struct packed {
		logic clr;
		logic load;
	} sq_ctrl_t;

endpackage

// ===== rtl/ebau_rem.sv =====
// ----------------------------------------------------------------------------
// ebau_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ebau_rem #(
	parameter int W = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [W-1:0]                dividend,
	input  logic [ebau_pkg::EPS_W-1:0]  divisor,
	output logic                        done,
	output logic [ebau_pkg::EPS_W-1:0]  rem
);
	import ebau_pkg::*;

	localparam int CW = $clog2(W);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [EPS_W-1:0] rem_q;
	logic [W-1:0]  quo_q;
	logic [EPS_W:0] trial;
	logic [EPS_W:0] diff;
	logic          geq;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign geq   = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(W-1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W-1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= geq ? diff[EPS_W-1:0] : trial[EPS_W-1:0];
			quo_q <= quo_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/ebau_sqacc.sv =====
// ----------------------------------------------------------------------------
// ebau_sqacc
// Shared squarer with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module ebau_sqacc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ebau_pkg::sq_ctrl_t         ctrl,
	input  logic [31:0]                operand,
	output logic                       pending,
	output logic [ebau_pkg::SQ_W-1:0]  acc
);
	import ebau_pkg::*;

	logic        prod_vld_s1;
	logic [63:0] prod_s1;
	logic [SQ_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctrl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= operand * operand;
		end
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + SQ_W'(prod_s1);
		end
	end

	assign pending = prod_vld_s1;
	assign acc     = acc_q;

endmodule

// ===== rtl/epsilon_box_archive_update_top.sv =====
// ----------------------------------------------------------------------------
// epsilon_box_archive_update_top
// Epsilon-box nondominated archive: one candidate vector per command.
// ----------------------------------------------------------------------------
// Usage: pulse start with obj_0..obj_3 while busy is low; the command is
// taken at that edge and busy stays high until the result. The result
// (accepted, archive_full, entry_count, progress_total) is on its ports for
// one cycle with done high; the receiver cannot stall it.
// epsilon is written over the APB port at address 0, by the user only while
// the block is idle (not enforced by the block); zero is used as one.
// Steps per command: the candidate box corners go through the shared
//   serial remainder unit, one objective after the other,
//   then the archive entries are scanned in turn, with a distance pass when
//   boxes are equal (shared squarer, one objective per cycle),
//   then the archive is compacted through the one-port store.
// Reset: archive empty, progress zero, epsilon 655; store contents are not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module epsilon_box_archive_update_top #(
	parameter int NUM_OBJECTIVES = 4,
	parameter int ARCHIVE_DEPTH  = 256,
	parameter int OBJ_WIDTH      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ebau_pkg::OBJ_PORT_W-1:0]   obj_0,
	input  logic [ebau_pkg::OBJ_PORT_W-1:0]   obj_1,
	input  logic [ebau_pkg::OBJ_PORT_W-1:0]   obj_2,
	input  logic [ebau_pkg::OBJ_PORT_W-1:0]   obj_3,
	output logic                              done,
	output logic                              accepted,
	output logic                              archive_full,
	output logic [ebau_pkg::CNT_OUT_W-1:0]    entry_count,
	output logic [31:0]                       progress_total,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import ebau_pkg::*;

	localparam int KW = $clog2(NUM_OBJECTIVES);
	localparam int AW = $clog2(ARCHIVE_DEPTH);
	localparam int CW = $clog2(ARCHIVE_DEPTH + 1);

	typedef logic [NUM_OBJECTIVES-1:0][OBJ_WIDTH-1:0] vec_t;

	ebau_state_t state_q, state_d;

	logic [EPS_W-1:0] eps_q;
	logic [EPS_W-1:0] eps_c_q;
	vec_t             cand_q;
	vec_t             corner_q;
	logic [EPS_W:0]   hi_q [NUM_OBJECTIVES];
	logic [KW-1:0]    k_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    w_q;
	logic [CW-1:0]    kept_q;
	logic [CW-1:0]    used_q;
	logic [31:0]      progress_q;
	logic             less_q;
	logic             greater_q;
	logic             keep_mem [ARCHIVE_DEPTH];
	logic             keep_rd_q;
	logic [SQ_W-1:0]  cdist_q;
	logic             accepted_q;
	logic             full_q;

	vec_t             mem [ARCHIVE_DEPTH];
	vec_t             rdata_q;
	logic             mem_rd;
	logic             mem_wr;
	logic [AW-1:0]    mem_waddr;
	vec_t             mem_wdata;

	logic [OBJ_PORT_W-1:0] in_obj [4];
	logic [KW-1:0]    k_next;
	logic             last_k;
	logic             last_i;
	logic             rem_start;
	logic [OBJ_WIDTH-1:0] rem_dividend;
	logic             rem_done;
	logic [EPS_W-1:0] rem_val;
	logic [OBJ_WIDTH-1:0] corner_new;
	sq_ctrl_t         sq_ctrl;
	logic [31:0]      sq_operand;
	logic             sq_pending;
	logic [SQ_W-1:0]  sq_acc;
	logic [OBJ_WIDTH-1:0] ent;
	logic             obj_gt;
	logic             obj_lt;
	logic             new_less;
	logic             new_greater;
	logic             cand_nearer;
	logic             cfg_wr;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign in_obj[0] = obj_0;
	assign in_obj[1] = obj_1;
	assign in_obj[2] = obj_2;
	assign in_obj[3] = obj_3;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_EPSILON);
	assign prdata = (paddr == REG_EPSILON) ? eps_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr) begin
			eps_q <= pwdata;
		end
	end

	assign k_next = k_q + 1'b1;
	assign last_k = (k_q == KW'(NUM_OBJECTIVES - 1));
	assign last_i = ((i_q + 1'b1) == used_q);

	// per-objective box test against the candidate box [corner, corner+eps)
	assign ent         = rdata_q[k_q];
	assign obj_gt      = ent < corner_q[k_q];
	assign obj_lt      = 33'(ent) >= hi_q[k_q];
	assign new_less    = less_q | obj_lt;
	assign new_greater = greater_q | obj_gt;
	assign cand_nearer = cdist_q < sq_acc;
	assign corner_new  = cand_q[k_q] - rem_val[OBJ_WIDTH-1:0];

	ebau_rem #(.W(OBJ_WIDTH)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (eps_c_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	ebau_sqacc u_sqacc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sq_ctrl),
		.operand (sq_operand),
		.pending (sq_pending),
		.acc     (sq_acc)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (rem_done && last_k) state_d = ST_DRAIN_C;
			end
			ST_DRAIN_C: begin
				if (!sq_pending) state_d = (used_q == '0) ? ST_DECIDE : ST_READ;
			end
			ST_READ: state_d = ST_CMP;
			ST_CMP: begin
				if (last_k) begin
					if (new_greater && !new_less) begin
						state_d = ST_DONE;
					end else if (!new_greater && !new_less) begin
						state_d = ST_DIST;
					end else begin
						state_d = last_i ? ST_DECIDE : ST_READ;
					end
				end
			end
			ST_DIST: begin
				if (last_k) state_d = ST_DRAIN_E;
			end
			ST_DRAIN_E: begin
				if (!sq_pending) begin
					if (!cand_nearer) state_d = ST_DONE;
					else state_d = last_i ? ST_DECIDE : ST_READ;
				end
			end
			ST_DECIDE: begin
				state_d = (kept_q == CW'(ARCHIVE_DEPTH)) ? ST_DONE : ST_CP_RD;
			end
			ST_CP_RD: begin
				state_d = (i_q == used_q) ? ST_DONE : ST_CP_WR;
			end
			ST_CP_WR: state_d = ST_CP_RD;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		rem_start    = 1'b0;
		rem_dividend = cand_q[k_next];
		sq_ctrl      = '0;
		sq_operand   = rem_val;
		mem_rd       = 1'b0;
		mem_wr       = 1'b0;
		mem_waddr    = w_q[AW-1:0];
		mem_wdata    = rdata_q;
		case (state_q)
			ST_IDLE: begin
				rem_start    = start;
				rem_dividend = in_obj[0][OBJ_WIDTH-1:0];
				sq_ctrl.clr  = start;
			end
			ST_DIV: begin
				rem_start    = rem_done && !last_k;
				sq_ctrl.load = rem_done;
			end
			ST_READ: mem_rd = 1'b1;
			ST_CMP: begin
				sq_ctrl.clr = last_k && !new_greater && !new_less;
			end
			ST_DIST: begin
				sq_ctrl.load = 1'b1;
				sq_operand   = 32'(ent - corner_q[k_q]);
			end
			ST_CP_RD: begin
				if (i_q == used_q) begin
					mem_wr    = 1'b1;
					mem_wdata = cand_q;
				end else begin
					mem_rd = 1'b1;
				end
			end
			// entry and its keep flag were read together in the cycle before
			ST_CP_WR: mem_wr = keep_rd_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr) mem[mem_waddr] <= mem_wdata;
		if (mem_rd) begin
			rdata_q   <= mem[i_q[AW-1:0]];
			keep_rd_q <= keep_mem[i_q[AW-1:0]];
		end
		if (state_q == ST_CMP && last_k) begin
			keep_mem[i_q[AW-1:0]] <= new_less && new_greater;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			progress_q <= '0;
			accepted_q <= 1'b0;
			full_q     <= 1'b0;
			k_q        <= '0;
			i_q        <= '0;
			w_q        <= '0;
			kept_q     <= '0;
			less_q     <= 1'b0;
			greater_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						k_q        <= '0;
						i_q        <= '0;
						kept_q     <= '0;
						accepted_q <= 1'b0;
						full_q     <= 1'b0;
					end
				end
				ST_DIV: begin
					if (rem_done) k_q <= last_k ? '0 : k_next;
				end
				ST_READ: begin
					k_q       <= '0;
					less_q    <= 1'b0;
					greater_q <= 1'b0;
				end
				ST_CMP: begin
					less_q    <= new_less;
					greater_q <= new_greater;
					k_q       <= last_k ? '0 : k_next;
					if (last_k) begin
						if (new_less && !new_greater) begin
							progress_q <= progress_q + 1'b1;
							i_q        <= i_q + 1'b1;
						end else if (new_less && new_greater) begin
							kept_q <= kept_q + 1'b1;
							i_q    <= i_q + 1'b1;
						end
					end
				end
				ST_DIST: k_q <= last_k ? '0 : k_next;
				ST_DRAIN_E: begin
					if (!sq_pending && cand_nearer) i_q <= i_q + 1'b1;
				end
				ST_DECIDE: begin
					i_q <= '0;
					w_q <= '0;
					if (kept_q == CW'(ARCHIVE_DEPTH)) full_q <= 1'b1;
				end
				ST_CP_RD: begin
					if (i_q == used_q) begin
						used_q     <= w_q + 1'b1;
						accepted_q <= 1'b1;
					end
				end
				ST_CP_WR: begin
					if (keep_rd_q) w_q <= w_q + 1'b1;
					i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			eps_c_q <= (eps_q == '0) ? EPS_W'(1) : eps_q;
			for (int j = 0; j < NUM_OBJECTIVES; j++) begin
				cand_q[j] <= in_obj[j][OBJ_WIDTH-1:0];
			end
		end
		if (state_q == ST_DIV && rem_done) begin
			corner_q[k_q] <= corner_new;
			hi_q[k_q]     <= 33'(corner_new) + {1'b0, eps_c_q};
		end
		if (state_q == ST_DRAIN_C && !sq_pending) begin
			cdist_q <= sq_acc;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = (state_q == ST_DONE);
	assign accepted       = accepted_q;
	assign archive_full   = full_q;
	assign cnt_ext        = {{CNT_OUT_W{1'b0}}, used_q};
	assign entry_count    = cnt_ext[CNT_OUT_W-1:0];
	assign progress_total = progress_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(accepted && archive_full))
		else $error("accepted and archive_full both set");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(ARCHIVE_DEPTH))
		else $error("entry count beyond archive depth");

endmodule
